// ----- rtl/core/imh_pkg.sv -----
`default_nettype none
package imh_pkg;

  localparam int CAPACITY     = 256;
  localparam int NUM_VERTICES = 256;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = IDX_W + 1;
  localparam int VTX_W        = 8;
  localparam int KEY_W        = 32;

  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] hrd_a;
    logic [IDX_W-1:0] hrd_b;
    logic             hwr_en;
    logic [IDX_W-1:0] hwr_addr;
    entry_t           hwr_data;
    logic [VTX_W-1:0] prd_addr;
    logic             pwr_en;
    logic [VTX_W-1:0] pwr_addr;
    logic [IDX_W-1:0] pwr_data;
    logic [VTX_W-1:0] look_vtx;
    logic             vset_en;
    logic             vclr_en;
    logic [VTX_W-1:0] vchg_vtx;
  } store_req_t;

  typedef struct packed {
    entry_t           rd_a;
    entry_t           rd_b;
    logic [IDX_W-1:0] slot;
    logic             hit;
  } store_rsp_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VTX_W-1:0] min_vertex;
    logic [KEY_W-1:0] min_key;
    logic             present;
    logic             heap_empty;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/indexed_min_heap.sv -----
// channel | dir | fields (lowest bit first)
// s_*     | in  | tuser: mode[1:0]; tdata: vertex[7:0], key[39:8]
// m_*     | out | tdata: status[1:0], min_vertex[9:2], min_key[41:10],
//         |     |        present[42], heap_empty[43], count[52:44]
// One transaction at a time. Query, no-op, an extract on an empty heap and a
// dropped insert go straight to the result; each heap level of a sift costs a
// read state then a compare-and-write-back state, for up to 256 entries.
// The sift loop relies on the heap RAM's registered read.
// rst clears count and presence bits; heap slots are never cleared.
// A stalled output holds the finished result; the next input waits for it.
`default_nettype none
module indexed_min_heap (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // vertex[7:0], key[39:8]
  input  wire  [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata    // status, min_vertex, min_key, present, heap_empty, count
);

  imh_pkg::store_req_t req;
  imh_pkg::store_rsp_t rsp;
  imh_pkg::result_t    result;
  logic                done;
  logic                out_free;

  assign out_free = !m_tvalid || m_tready;

  imh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser),
    .in_vertex(s_tdata[7:0]),
    .in_key   (s_tdata[39:8]),
    .out_free (out_free),
    .done     (done),
    .result   (result),
    .req      (req),
    .rsp      (rsp)
  );

  imh_store u_store (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {3'b000, result.count, result.heap_empty, result.present,
                  result.min_key, result.min_vertex, result.status};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/imh_store.sv -----
`default_nettype none
module imh_store (
  input  wire                  clk,
  input  wire                  rst,
  input  imh_pkg::store_req_t  req,
  output imh_pkg::store_rsp_t  rsp
);

  imh_pkg::entry_t                 heap_mem [imh_pkg::CAPACITY];
  logic [imh_pkg::IDX_W-1:0]       pos_mem  [imh_pkg::NUM_VERTICES];
  logic [imh_pkg::NUM_VERTICES-1:0] valid;
  imh_pkg::entry_t                 rd_a;
  imh_pkg::entry_t                 rd_b;
  logic [imh_pkg::IDX_W-1:0]       slot;

  always_ff @(posedge clk) begin
    if (req.hwr_en) begin
      heap_mem[req.hwr_addr] <= req.hwr_data;
    end
    rd_a <= heap_mem[req.hrd_a];
    rd_b <= heap_mem[req.hrd_b];
  end

  always_ff @(posedge clk) begin
    if (req.pwr_en) begin
      pos_mem[req.pwr_addr] <= req.pwr_data;
    end
    slot <= pos_mem[req.prd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.vset_en) begin
      valid[req.vchg_vtx] <= 1'b1;
    end else if (req.vclr_en) begin
      valid[req.vchg_vtx] <= 1'b0;
    end
  end

  assign rsp.rd_a = rd_a;
  assign rsp.rd_b = rd_b;
  assign rsp.slot = slot;
  assign rsp.hit  = valid[req.look_vtx];

endmodule
`default_nettype wire

// ----- rtl/core/imh_ctrl.sv -----
`default_nettype none
module imh_ctrl (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       in_mode,
  input  wire  [imh_pkg::VTX_W-1:0]        in_vertex,
  input  wire  [imh_pkg::KEY_W-1:0]        in_key,
  input  wire                              out_free,
  output logic                             done,
  output imh_pkg::result_t                 result,
  output imh_pkg::store_req_t              req,
  input  imh_pkg::store_rsp_t              rsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_OLD  = 4'd2;
  localparam logic [3:0] S_UPRD = 4'd3;
  localparam logic [3:0] S_UPEV = 4'd4;
  localparam logic [3:0] S_DNRD = 4'd5;
  localparam logic [3:0] S_DNEV = 4'd6;
  localparam logic [3:0] S_EXRD = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]                state, state_next;
  logic [imh_pkg::IDX_W-1:0] idx, idx_next;
  logic [imh_pkg::IDX_W-1:0] par, par_next;
  logic [imh_pkg::CNT_W-1:0] count, count_next;
  imh_pkg::entry_t           item, item_next;
  logic [1:0]                status, status_next;
  imh_pkg::entry_t           min_e, min_e_next;
  logic                      present, present_next;

  // children of idx, one bit wider so 2i+2 never wraps
  logic [imh_pkg::CNT_W:0]   lc, rc;
  logic                      take_l, take_r;
  logic [imh_pkg::KEY_W-1:0] best_key;

  assign lc       = {1'b0, idx, 1'b1};
  assign rc       = lc + 1'b1;
  assign take_l   = (lc < {1'b0, count}) && (rsp.rd_a.key < item.key);
  assign best_key = take_l ? rsp.rd_a.key : item.key;
  assign take_r   = (rc < {1'b0, count}) && (rsp.rd_b.key < best_key);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    par_next     = par;
    count_next   = count;
    item_next    = item;
    status_next  = status;
    min_e_next   = min_e;
    present_next = present;
    done         = 1'b0;
    req          = '0;
    req.look_vtx = in_vertex;
    req.prd_addr = in_vertex;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next  = imh_pkg::ST_OK;
          min_e_next   = '0;
          present_next = 1'b0;
          item_next    = '{vertex: in_vertex, key: in_key};
          state_next   = S_FIN;
          if (in_mode == imh_pkg::MODE_UPDATE) begin
            if (rsp.hit) begin
              state_next = S_LOOK;
            end else if (count == imh_pkg::CNT_W'(imh_pkg::CAPACITY)) begin
              status_next = imh_pkg::ST_FULL;
            end else begin
              idx_next     = count[imh_pkg::IDX_W-1:0];
              count_next   = count + 1'b1;
              req.vset_en  = 1'b1;
              req.vchg_vtx = in_vertex;
              state_next   = S_UPRD;
            end
          end else if (in_mode == imh_pkg::MODE_EXTRACT) begin
            if (count == '0) begin
              status_next = imh_pkg::ST_EMPTY;
            end else begin
              req.hrd_a  = '0;
              req.hrd_b  = imh_pkg::IDX_W'(count - 1'b1);
              count_next = count - 1'b1;
              state_next = S_EXRD;
            end
          end else if (in_mode == imh_pkg::MODE_QUERY) begin
            present_next = rsp.hit;
          end
        end
      end
      S_LOOK: begin
        idx_next   = rsp.slot;
        req.hrd_a  = rsp.slot;
        state_next = S_OLD;
      end
      S_OLD: begin
        if (item.key < rsp.rd_a.key) begin
          state_next = S_UPRD;
        end else if (item.key > rsp.rd_a.key) begin
          state_next = S_DNRD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_UPRD: begin
        if (idx == '0) begin
          req.hwr_en   = 1'b1;
          req.hwr_addr = idx;
          req.hwr_data = item;
          req.pwr_en   = 1'b1;
          req.pwr_addr = item.vertex;
          req.pwr_data = idx;
          state_next   = S_FIN;
        end else begin
          par_next   = (idx - 1'b1) >> 1;
          req.hrd_a  = (idx - 1'b1) >> 1;
          state_next = S_UPEV;
        end
      end
      S_UPEV: begin
        req.hwr_en   = 1'b1;
        req.hwr_addr = idx;
        req.pwr_en   = 1'b1;
        req.pwr_data = idx;
        if (item.key < rsp.rd_a.key) begin
          // parent moves down into the hole
          req.hwr_data = rsp.rd_a;
          req.pwr_addr = rsp.rd_a.vertex;
          idx_next     = par;
          state_next   = S_UPRD;
        end else begin
          req.hwr_data = item;
          req.pwr_addr = item.vertex;
          state_next   = S_FIN;
        end
      end
      S_DNRD: begin
        req.hrd_a  = lc[imh_pkg::IDX_W-1:0];
        req.hrd_b  = rc[imh_pkg::IDX_W-1:0];
        state_next = S_DNEV;
      end
      S_DNEV: begin
        req.hwr_en   = 1'b1;
        req.hwr_addr = idx;
        req.pwr_en   = 1'b1;
        req.pwr_data = idx;
        if (take_r) begin
          req.hwr_data = rsp.rd_b;
          req.pwr_addr = rsp.rd_b.vertex;
          idx_next     = rc[imh_pkg::IDX_W-1:0];
          state_next   = S_DNRD;
        end else if (take_l) begin
          req.hwr_data = rsp.rd_a;
          req.pwr_addr = rsp.rd_a.vertex;
          idx_next     = lc[imh_pkg::IDX_W-1:0];
          state_next   = S_DNRD;
        end else begin
          req.hwr_data = item;
          req.pwr_addr = item.vertex;
          state_next   = S_FIN;
        end
      end
      S_EXRD: begin
        min_e_next   = rsp.rd_a;
        req.vclr_en  = 1'b1;
        req.vchg_vtx = rsp.rd_a.vertex;
        if (count == '0) begin
          state_next = S_FIN;
        end else begin
          item_next  = rsp.rd_b;
          idx_next   = '0;
          state_next = S_DNRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    par     <= par_next;
    item    <= item_next;
    status  <= status_next;
    min_e   <= min_e_next;
    present <= present_next;
  end

  assign result.status     = status;
  assign result.min_vertex = min_e.vertex;
  assign result.min_key    = min_e.key;
  assign result.present    = present;
  assign result.heap_empty = (count == '0);
  assign result.count      = count;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= imh_pkg::CNT_W'(imh_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_write_live: assert property (@(posedge clk) disable iff (rst)
    req.hwr_en |-> ({1'b0, req.hwr_addr} < count))
    else $error("heap write outside live slots");

  a_fin_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (state == S_IDLE))
    else $error("result not released");

endmodule
`default_nettype wire
